[hdl/scl_pkg.sv]
package scl_pkg;

    localparam int MARKER_BYTES = 4;
    localparam int MARKER_W     = 8 * MARKER_BYTES;
    localparam int HIST_W       = 8 * (MARKER_BYTES - 1);
    localparam int CNT_W        = $clog2(MARKER_BYTES + 2);
    localparam int LEAD_MAX     = MARKER_BYTES + 1;

    localparam logic [1:0] MODE_GENERIC = 2'd0;
    localparam logic [1:0] MODE_FENCED  = 2'd1;
    localparam logic [1:0] MODE_PLAIN   = 2'd2;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_LINE  = 3'd1;
    localparam logic [2:0] CFG_OPEN  = 3'd2;
    localparam logic [2:0] CFG_CLOSE = 3'd3;
    localparam logic [2:0] CFG_FENCE = 3'd4;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_EOF  = 1'b1;

    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_VT    = 8'h0B;
    localparam logic [7:0] BYTE_FF    = 8'h0C;
    localparam logic [7:0] BYTE_CR    = 8'h0D;

    typedef struct packed {
        logic [1:0]          mode;
        logic [MARKER_W-1:0] line_marker;
        logic [MARKER_W-1:0] open_marker;
        logic [MARKER_W-1:0] close_marker;
        logic [MARKER_W-1:0] fence_marker;
    } t_cfg;

    typedef struct packed {
        logic is_blank;
        logic is_comment;
        logic is_code;
    } t_result;

    typedef struct packed {
        logic [HIST_W-1:0] recent;
        logic              has_bytes;
        logic              nonblank;
        logic              non_space_tab;
        logic [CNT_W-1:0]  prefix_cnt;
        logic              prefix_failed;
        logic              opener_found;
        logic              code_before;
        logic [CNT_W-1:0]  since_marker;
        logic              closer_found;
        logic              code_after;
        logic [CNT_W-1:0]  lead_age;
    } t_line;

    function automatic logic [CNT_W-1:0] marker_len(input logic [MARKER_W-1:0] m);
        logic [CNT_W-1:0] n;
        logic             stop;
        n    = '0;
        stop = 1'b0;
        for (int k = 0; k < MARKER_BYTES; k++) begin
            if (!stop && m[MARKER_W-1-8*k -: 8] != 8'h00) begin
                n = n + CNT_W'(1);
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] marker_byte(input logic [MARKER_W-1:0] m,
                                               input logic [CNT_W-1:0] idx);
        logic [MARKER_W-1:0] sh;
        sh = m >> (8 * (MARKER_BYTES - 1 - int'(idx)));
        return sh[7:0];
    endfunction

    // marker of length len (>= 1) ends at the newest byte of win
    function automatic logic window_match(input logic [MARKER_W-1:0] m,
                                          input logic [CNT_W-1:0] len,
                                          input logic [MARKER_W-1:0] win);
        logic [MARKER_W-1:0] aligned;
        logic [MARKER_W-1:0] mask;
        aligned = win << (8 * (MARKER_BYTES - int'(len)));
        mask    = {MARKER_W{1'b1}} << (8 * (MARKER_BYTES - int'(len)));
        return ((aligned ^ m) & mask) == '0;
    endfunction

endpackage

[hdl/scl_line_state.sv]
module scl_line_state (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  scl_pkg::t_cfg   i_cfg,
    input  logic            i_take,
    input  logic            i_kind,
    input  logic [7:0]      i_char_byte,
    output logic            o_res_valid,
    output scl_pkg::t_result o_res
);

    logic           r_in_block;
    logic           r_in_fence;
    scl_pkg::t_line r_line;
    logic           n_in_block;
    logic           n_in_fence;
    scl_pkg::t_line n_line;

    logic [scl_pkg::CNT_W-1:0] len_line;
    logic [scl_pkg::CNT_W-1:0] len_open;
    logic [scl_pkg::CNT_W-1:0] len_close;
    logic [scl_pkg::CNT_W-1:0] len_fence;

    scl_pkg::t_result f_res;
    logic             f_in_block;
    logic             f_in_fence;

    scl_pkg::t_line               t;
    logic                         sp_tab;
    logic                         blank_char;
    logic [scl_pkg::MARKER_W-1:0] pm;
    logic [scl_pkg::CNT_W-1:0]    pm_len;
    logic                         active;
    logic [scl_pkg::MARKER_W-1:0] win;
    logic                         close_hit;
    logic                         open_hit;

    assign len_line  = scl_pkg::marker_len(i_cfg.line_marker);
    assign len_open  = scl_pkg::marker_len(i_cfg.open_marker);
    assign len_close = scl_pkg::marker_len(i_cfg.close_marker);
    assign len_fence = scl_pkg::marker_len(i_cfg.fence_marker);

    // line end classification
    always_comb begin
        f_res      = '0;
        f_in_block = r_in_block;
        f_in_fence = r_in_fence;
        if (!r_line.nonblank) begin
            f_res.is_blank = 1'b1;
        end else if (i_cfg.mode == scl_pkg::MODE_FENCED) begin
            if (!r_line.prefix_failed && r_line.prefix_cnt >= len_fence) begin
                f_in_fence = !r_in_fence;
            end else if (r_in_fence) begin
                f_res.is_code = 1'b1;
            end
        end else if (i_cfg.mode != scl_pkg::MODE_GENERIC) begin
            f_res.is_code = 1'b1;
        end else if (r_in_block) begin
            f_res.is_comment = 1'b1;
            if (r_line.closer_found) begin
                f_in_block    = 1'b0;
                f_res.is_code = r_line.code_after;
            end
        end else if (len_line != '0 && !r_line.prefix_failed
                     && r_line.prefix_cnt >= len_line) begin
            f_res.is_comment = 1'b1;
        end else if (r_line.opener_found) begin
            f_res.is_comment = 1'b1;
            if (!r_line.closer_found && len_close != '0) begin
                f_in_block = 1'b1;
            end
            f_res.is_code = r_line.code_before;
        end else begin
            f_res.is_code = 1'b1;
        end
    end

    // per-byte update
    always_comb begin
        sp_tab     = (i_char_byte == scl_pkg::BYTE_SPACE) || (i_char_byte == scl_pkg::BYTE_TAB);
        blank_char = sp_tab || (i_char_byte == scl_pkg::BYTE_VT)
                     || (i_char_byte == scl_pkg::BYTE_FF) || (i_char_byte == scl_pkg::BYTE_CR);
        win        = {r_line.recent, i_char_byte};
        pm         = (i_cfg.mode == scl_pkg::MODE_FENCED) ? i_cfg.fence_marker
                                                          : i_cfg.line_marker;
        pm_len     = (i_cfg.mode == scl_pkg::MODE_FENCED) ? len_fence : len_line;

        t           = r_line;
        t.has_bytes = 1'b1;
        if (!blank_char) begin
            t.nonblank = 1'b1;
        end
        if (!sp_tab) begin
            t.non_space_tab = 1'b1;
        end
        if (t.non_space_tab && t.lead_age < scl_pkg::CNT_W'(scl_pkg::LEAD_MAX)) begin
            t.lead_age = t.lead_age + scl_pkg::CNT_W'(1);
        end

        active = (i_cfg.mode == scl_pkg::MODE_FENCED) || t.non_space_tab;
        if ((i_cfg.mode == scl_pkg::MODE_GENERIC || i_cfg.mode == scl_pkg::MODE_FENCED)
            && active && !t.prefix_failed && t.prefix_cnt < pm_len) begin
            if (i_char_byte == scl_pkg::marker_byte(pm, t.prefix_cnt)) begin
                t.prefix_cnt = t.prefix_cnt + scl_pkg::CNT_W'(1);
            end else begin
                t.prefix_failed = 1'b1;
            end
        end

        if (i_cfg.mode == scl_pkg::MODE_GENERIC && (r_in_block || r_line.opener_found)
            && t.since_marker < scl_pkg::CNT_W'(scl_pkg::MARKER_BYTES)) begin
            t.since_marker = t.since_marker + scl_pkg::CNT_W'(1);
        end
        close_hit = (len_close != '0) && (t.since_marker >= len_close)
                    && scl_pkg::window_match(i_cfg.close_marker, len_close, win);
        open_hit  = (len_open != '0)
                    && scl_pkg::window_match(i_cfg.open_marker, len_open, win);

        if (i_cfg.mode == scl_pkg::MODE_GENERIC) begin
            if (r_in_block) begin
                if (r_line.closer_found && !sp_tab) begin
                    t.code_after = 1'b1;
                end
                if (!r_line.closer_found && close_hit) begin
                    t.closer_found = 1'b1;
                end
            end else begin
                if (r_line.opener_found && !r_line.closer_found && close_hit) begin
                    t.closer_found = 1'b1;
                end
                if (!r_line.opener_found && open_hit) begin
                    t.opener_found = 1'b1;
                    t.code_before  = t.non_space_tab && (t.lead_age > len_open);
                end
            end
        end

        t.recent = win[scl_pkg::HIST_W-1:0];
    end

    always_comb begin
        n_in_block  = r_in_block;
        n_in_fence  = r_in_fence;
        n_line      = r_line;
        o_res_valid = 1'b0;
        o_res       = f_res;
        if (i_take) begin
            if (i_kind == scl_pkg::KIND_EOF) begin
                o_res_valid = r_line.has_bytes;
                n_in_block  = 1'b0;
                n_in_fence  = 1'b0;
                n_line      = '0;
            end else if (i_char_byte == scl_pkg::BYTE_LF) begin
                o_res_valid = 1'b1;
                n_in_block  = f_in_block;
                n_in_fence  = f_in_fence;
                n_line      = '0;
            end else begin
                n_line = t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_block <= 1'b0;
            r_in_fence <= 1'b0;
            r_line     <= '0;
        end else begin
            r_in_block <= n_in_block;
            r_in_fence <= n_in_fence;
            r_line     <= n_line;
        end
    end

endmodule

[hdl/scl_out_reg.sv]
module scl_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  scl_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output scl_pkg::t_result o_res
);

    logic             r_valid;
    logic             n_valid;
    scl_pkg::t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

[hdl/source_line_classifier_unit.sv]
// Source line classifier.
// Input channel (i_in_valid / o_in_ready) carries one text byte per transfer
// (i_kind = 0) or an end-of-file mark (i_kind = 1). A 0x0A byte closes a line;
// end of file closes a pending unterminated line and clears all line and
// block/fence state.
// Output channel (o_out_valid / i_out_ready) carries one transfer per closed
// line: o_is_blank, o_is_comment, o_is_code.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes register
// i_cfg_index: 0 mode, 1 line marker, 2 block opener, 3 block closer,
// 4 fence marker. Other indexes are dropped. Write only while idle.
// Output: a line result is registered and appears in the cycle after the byte
// that closes it is taken. Throughput: one byte per cycle while the single
// result register is free; the per-byte state update is combinational.
// Stall: while the result register holds an untaken result, o_in_ready
// drops until i_out_ready is seen.
// Reset (synchronous, active low): config registers to zero, all state
// cleared, output empty. No clearing pass.
module source_line_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_char_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_blank,
    output logic        o_is_comment,
    output logic        o_is_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [1:0]                   r_mode;
    logic [scl_pkg::MARKER_W-1:0] r_line_marker;
    logic [scl_pkg::MARKER_W-1:0] r_open_marker;
    logic [scl_pkg::MARKER_W-1:0] r_close_marker;
    logic [scl_pkg::MARKER_W-1:0] r_fence_marker;

    scl_pkg::t_cfg    cfg;
    logic             take;
    logic             free;
    logic             res_valid;
    scl_pkg::t_result res;
    scl_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= scl_pkg::MODE_GENERIC;
            r_line_marker  <= '0;
            r_open_marker  <= '0;
            r_close_marker <= '0;
            r_fence_marker <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                scl_pkg::CFG_MODE:  r_mode         <= i_cfg_data[1:0];
                scl_pkg::CFG_LINE:  r_line_marker  <= i_cfg_data;
                scl_pkg::CFG_OPEN:  r_open_marker  <= i_cfg_data;
                scl_pkg::CFG_CLOSE: r_close_marker <= i_cfg_data;
                scl_pkg::CFG_FENCE: r_fence_marker <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode         = r_mode;
        cfg.line_marker  = r_line_marker;
        cfg.open_marker  = r_open_marker;
        cfg.close_marker = r_close_marker;
        cfg.fence_marker = r_fence_marker;
    end

    assign o_in_ready = free;
    assign take       = i_in_valid && free;

    scl_line_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_take      (take),
        .i_kind      (i_kind),
        .i_char_byte (i_char_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    scl_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_is_blank   = out_res.is_blank;
    assign o_is_comment = out_res.is_comment;
    assign o_is_code    = out_res.is_code;

endmodule
